// File: sv/vpts_pkg.sv
// Shared types, register indexes and saturation helper for the vertex projection block.
package vpts_pkg;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vertex_w;
  } vertex_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               divide_error;
  } screen_out_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cw;
  } clip_t;

  typedef logic signed [31:0] coef_t;
  typedef coef_t [2:0][3:0] coef_mat_t;

  localparam int QDepth = 4;

  localparam logic [3:0] RegRow0C01 = 4'd0;
  localparam logic [3:0] RegRow0C23 = 4'd1;
  localparam logic [3:0] RegRow1C01 = 4'd2;
  localparam logic [3:0] RegRow1C23 = 4'd3;
  localparam logic [3:0] RegRow3C01 = 4'd4;
  localparam logic [3:0] RegRow3C23 = 4'd5;
  localparam logic [3:0] RegWidth   = 4'd6;
  localparam logic [3:0] RegHeight  = 4'd7;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = {{36{1'b0}}, S32Max};
    lo = {{36{1'b1}}, S32Min};
    if (v > hi) return S32Max;
    if (v < lo) return S32Min;
    return v[31:0];
  endfunction

endpackage

// File: sv/vertex_project_to_screen_core.sv
// Top level of the vertex projection block: configuration registers and the two halves.
//
// Usage: one vertex word (x, y, z, w, signed fixed point) enters on in_valid/in_ready
// and yields exactly one screen word (screen_x, screen_y, divide_error) on
// out_valid/out_ready, in order. The matrix rows 0, 1, 3 and the viewport size are
// written on cfg_valid/cfg_index/cfg_data; cfg_ready is always high, unknown
// indexes are dropped. Write configuration only while the block is empty.
// Throughput: one word per clock while the receiver takes words. The pipeline is the
// 32-stage quotient pipeline (one bit per stage) plus 3 front stages, the queue and
// 4 back stages for prep, sign/saturate, viewport multiply and output register.
// Reset loads the identity-style matrix and a 640 x 480 viewport and empties
// all pipelines. When the receiver stalls, the back end holds; the front end
// keeps taking words until the 4-entry queue fills, then in_ready drops.
module vertex_project_to_screen_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vpts_pkg::vertex_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vpts_pkg::screen_out_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_index,
  input  logic [63:0]            cfg_data
);
  import vpts_pkg::*;

  localparam logic [63:0] One = 64'd1 << FRAC_BITS;

  logic [63:0] row0_01, row0_23, row1_01, row1_23, row3_01, row3_23;
  logic [12:0] screen_width, screen_height;
  coef_mat_t   coef;
  logic        q_full, q_empty, push, pop;
  clip_t       push_data, pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_01       <= One;
      row0_23       <= '0;
      row1_01       <= One << 32;
      row1_23       <= '0;
      row3_01       <= '0;
      row3_23       <= One << 32;
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegRow0C01: row0_01       <= cfg_data;
        RegRow0C23: row0_23       <= cfg_data;
        RegRow1C01: row1_01       <= cfg_data;
        RegRow1C23: row1_23       <= cfg_data;
        RegRow3C01: row3_01       <= cfg_data;
        RegRow3C23: row3_23       <= cfg_data;
        RegWidth:   screen_width  <= cfg_data[12:0];
        RegHeight:  screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients, even columns in the low half.
  assign coef[0][0] = row0_01[31:0];
  assign coef[0][1] = row0_01[63:32];
  assign coef[0][2] = row0_23[31:0];
  assign coef[0][3] = row0_23[63:32];
  assign coef[1][0] = row1_01[31:0];
  assign coef[1][1] = row1_01[63:32];
  assign coef[1][2] = row1_23[31:0];
  assign coef[1][3] = row1_23[63:32];
  assign coef[2][0] = row3_01[31:0];
  assign coef[2][1] = row3_01[63:32];
  assign coef[2][2] = row3_23[31:0];
  assign coef[2][3] = row3_23[63:32];

  vpts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .coef      (coef),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  vpts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  vpts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .width_px  (screen_width),
    .height_px (screen_height),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A zero clip w yields zero coordinates.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |-> out_data.screen_x == '0 && out_data.screen_y == '0)
    else $error("divide error word carries nonzero coordinates");

  // No word appears right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The queue never pushes and reports full in the same cycle.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("push into full queue");

endmodule

// File: sv/vpts_front.sv
// Front end: vertex capture, matrix multiply and clip-space sums.
module vpts_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vpts_pkg::vertex_in_t   in_data,
  input  vpts_pkg::coef_mat_t    coef,
  input  logic                   q_full,
  output logic                   push,
  output vpts_pkg::clip_t        push_data
);
  import vpts_pkg::*;

  logic               fe;
  logic               v0, v1, v2;
  vertex_in_t         vin;
  logic signed [31:0] vec [4];
  logic signed [63:0] prod [3][4];
  clip_t              clip;
  logic signed [67:0] acc [3];

  // Stall the whole front only when its last word cannot enter the queue.
  assign fe       = !(v2 && q_full);
  assign in_ready = fe;
  assign push     = v2 && !q_full;
  assign push_data = clip;

  assign vec[0] = vin.vertex_x;
  assign vec[1] = vin.vertex_y;
  assign vec[2] = vin.vertex_z;
  assign vec[3] = vin.vertex_w;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (fe) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // Capture the vertex.
  always_ff @(posedge clk) begin
    if (fe && in_valid) begin
      vin <= in_data;
    end
  end

  // Form the twelve exact products.
  always_ff @(posedge clk) begin
    if (fe) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= coef[r][c] * vec[c];
        end
      end
    end
  end

  // Floor-shift each product, sum per row.
  always_comb begin
    logic signed [63:0] sh;
    for (int r = 0; r < 3; r++) begin
      acc[r] = '0;
      for (int c = 0; c < 4; c++) begin
        sh = prod[r][c] >>> FRAC_BITS;
        acc[r] = acc[r] + {{4{sh[63]}}, sh};
      end
    end
  end

  // Register saturated clip coordinates.
  always_ff @(posedge clk) begin
    if (fe) begin
      clip.cx <= sat32(acc[0]);
      clip.cy <= sat32(acc[1]);
      clip.cw <= sat32(acc[2]);
    end
  end

endmodule

// File: sv/vpts_queue.sv
// Short queue of clip-space words between the front and the back.
module vpts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vpts_pkg::clip_t  push_data,
  output logic             full,
  input  logic             pop,
  output vpts_pkg::clip_t  pop_data,
  output logic             empty
);
  import vpts_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  clip_t             mem [QDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count;

  assign full     = (count == (PtrW+1)'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store the pushed word.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/vpts_back.sv
// Back end: pipelined divide by clip w, viewport scale and output register.
module vpts_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  vpts_pkg::clip_t        q_data,
  output logic                   q_pop,
  input  logic [12:0]            width_px,
  input  logic [12:0]            height_px,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vpts_pkg::screen_out_t  out_data
);
  import vpts_pkg::*;

  localparam int DW    = 32 + FRAC_BITS;
  localparam int Steps = 32;

  logic be;

  // Divider pipeline, stage 0 is the prep stage.
  logic        dv_v   [Steps+1];
  logic [31:0] rem_x  [Steps+1];
  logic [31:0] rem_y  [Steps+1];
  logic [31:0] lo_x   [Steps+1];
  logic [31:0] lo_y   [Steps+1];
  logic [31:0] q_x    [Steps+1];
  logic [31:0] q_y    [Steps+1];
  logic [31:0] dvs    [Steps+1];
  logic        neg_x  [Steps+1];
  logic        neg_y  [Steps+1];
  logic        ovf_x  [Steps+1];
  logic        ovf_y  [Steps+1];
  logic        err    [Steps+1];

  logic [31:0]        mag_x, mag_y, mag_w;
  logic [DW-1:0]      d_x, d_y;
  logic [31:0]        hi_x, hi_y;

  logic               vn, vm;
  logic signed [31:0] n_x, n_y;
  logic               err_n, err_m;
  logic signed [45:0] pm_x, pm_y;
  logic signed [31:0] n_x_next, n_y_next;
  logic signed [67:0] centre_x, centre_y, half_x, half_y;

  // Stall every back stage while the output word waits.
  assign be    = !(out_valid && !out_ready);
  assign q_pop = be && !q_empty;

  // Magnitudes and the dividend split.
  always_comb begin
    mag_x = q_data.cx[31] ? 32'(-q_data.cx) : q_data.cx;
    mag_y = q_data.cy[31] ? 32'(-q_data.cy) : q_data.cy;
    mag_w = q_data.cw[31] ? 32'(-q_data.cw) : q_data.cw;
    d_x   = {mag_x, {FRAC_BITS{1'b0}}};
    d_y   = {mag_y, {FRAC_BITS{1'b0}}};
    hi_x  = {{(32-FRAC_BITS){1'b0}}, d_x[DW-1:32]};
    hi_y  = {{(32-FRAC_BITS){1'b0}}, d_y[DW-1:32]};
  end

  // Prep stage: signs, overflow checks, zero-w flag and initial remainders.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (be) begin
      dv_v[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      rem_x[0] <= hi_x;
      rem_y[0] <= hi_y;
      lo_x[0]  <= d_x[31:0];
      lo_y[0]  <= d_y[31:0];
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      dvs[0]   <= mag_w;
      neg_x[0] <= q_data.cx[31] ^ q_data.cw[31];
      neg_y[0] <= q_data.cy[31] ^ q_data.cw[31];
      ovf_x[0] <= hi_x >= mag_w;
      ovf_y[0] <= hi_y >= mag_w;
      err[0]   <= q_data.cw == '0;
    end
  end

  // One quotient bit per stage for each of x and y.
  for (genvar k = 1; k <= Steps; k++) begin : g_div
    logic [32:0] t_x, t_y;
    logic        ge_x, ge_y;

    assign t_x  = {rem_x[k-1], lo_x[k-1][31]};
    assign t_y  = {rem_y[k-1], lo_y[k-1][31]};
    assign ge_x = t_x >= {1'b0, dvs[k-1]};
    assign ge_y = t_y >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (be) begin
        dv_v[k] <= dv_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        rem_x[k] <= ge_x ? 32'(t_x - {1'b0, dvs[k-1]}) : t_x[31:0];
        rem_y[k] <= ge_y ? 32'(t_y - {1'b0, dvs[k-1]}) : t_y[31:0];
        lo_x[k]  <= {lo_x[k-1][30:0], 1'b0};
        lo_y[k]  <= {lo_y[k-1][30:0], 1'b0};
        q_x[k]   <= {q_x[k-1][30:0], ge_x};
        q_y[k]   <= {q_y[k-1][30:0], ge_y};
        dvs[k]   <= dvs[k-1];
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
        ovf_x[k] <= ovf_x[k-1];
        ovf_y[k] <= ovf_y[k-1];
        err[k]   <= err[k-1];
      end
    end
  end

  // Apply sign and saturate the quotients.
  always_comb begin
    if (!neg_x[Steps]) begin
      n_x_next = (ovf_x[Steps] || q_x[Steps][31]) ? S32Max : q_x[Steps];
    end else begin
      n_x_next = (ovf_x[Steps] || q_x[Steps] > 32'h8000_0000) ? S32Min
               : ~q_x[Steps] + 32'd1;
    end
    if (!neg_y[Steps]) begin
      n_y_next = (ovf_y[Steps] || q_y[Steps][31]) ? S32Max : q_y[Steps];
    end else begin
      n_y_next = (ovf_y[Steps] || q_y[Steps] > 32'h8000_0000) ? S32Min
               : ~q_y[Steps] + 32'd1;
    end
  end

  // Viewport: centre plus or minus half of the scaled coordinate.
  always_comb begin
    half_x   = $signed({{22{pm_x[45]}}, pm_x}) >>> 1;
    half_y   = $signed({{22{pm_y[45]}}, pm_y}) >>> 1;
    centre_x = $signed({55'd0, width_px}) <<< (FRAC_BITS - 1);
    centre_y = $signed({55'd0, height_px}) <<< (FRAC_BITS - 1);
  end

  // Valid bits of the tail stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vn        <= 1'b0;
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else if (be) begin
      vn        <= dv_v[Steps];
      vm        <= vn;
      out_valid <= vm;
    end
  end

  // Tail payload: quotient, scale, output word.
  always_ff @(posedge clk) begin
    if (be) begin
      n_x   <= n_x_next;
      n_y   <= n_y_next;
      err_n <= err[Steps];
      pm_x  <= n_x * $signed({1'b0, width_px});
      pm_y  <= n_y * $signed({1'b0, height_px});
      err_m <= err_n;
      if (err_m) begin
        out_data.screen_x <= '0;
        out_data.screen_y <= '0;
      end else begin
        out_data.screen_x <= sat32(centre_x + half_x);
        out_data.screen_y <= sat32(centre_y - half_y);
      end
      out_data.divide_error <= err_m;
    end
  end

endmodule

// File: tb/tb_vertex_project_to_screen_core.sv
// Testbench for the vertex projection block: random and directed vertices against a predictor.
`timescale 1ns / 1ps

module tb_vertex_project_to_screen_core;
  import vpts_pkg::*;

  localparam int FRAC = 16;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  vertex_in_t in_data;
  logic out_valid;
  logic out_ready;
  screen_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_index;
  logic [63:0] cfg_data;

  // Shadow copy of the configuration registers
  logic [63:0] mat_regs [0:5];
  logic [12:0] vp_width;
  logic [12:0] vp_height;

  screen_out_t expected_screen [$];
  int mismatch_count;
  int unexpected_count;
  bit hold_off;

  vertex_project_to_screen_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                   input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] coef_at(input int reg_base, input int col);
    logic [63:0] r;
    r = mat_regs[reg_base + col / 2];
    return (col % 2) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
  endfunction

  // Dot product of one matrix row with the vertex, saturated
  function automatic logic signed [63:0] clip_row(input int reg_base, input vertex_in_t v);
    logic signed [63:0] acc;
    logic signed [63:0] comp [0:3];
    acc = 0;
    comp[0] = v.vertex_x;
    comp[1] = v.vertex_y;
    comp[2] = v.vertex_z;
    comp[3] = v.vertex_w;
    for (int c = 0; c < 4; c++) acc += floor_shr(coef_at(reg_base, c) * comp[c], FRAC);
    return clamp32(acc);
  endfunction

  function automatic logic signed [63:0] viewport_map(input logic signed [63:0] clip,
                                                      input logic signed [63:0] cw,
                                                      input logic [12:0] size,
                                                      input bit flip);
    logic signed [63:0] n;
    logic signed [63:0] half;
    logic signed [63:0] centre;
    logic signed [63:0] sz;
    sz = {51'd0, size};
    n = clamp32((clip * 64'sd65536) / cw);
    half = floor_shr(n * sz, 1);
    centre = sz * (64'sd1 <<< (FRAC - 1));
    return clamp32(flip ? centre - half : centre + half);
  endfunction

  function automatic screen_out_t project_vertex(input vertex_in_t v);
    screen_out_t r;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] cw;
    cx = clip_row(0, v);
    cy = clip_row(2, v);
    cw = clip_row(4, v);
    r = '0;
    if (cw == 0) begin
      r.divide_error = 1'b1;
    end else begin
      r.screen_x = 32'(viewport_map(cx, cw, vp_width, 1'b0));
      r.screen_y = 32'(viewport_map(cy, cw, vp_height, 1'b1));
    end
    return r;
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Send one vertex word, after a random gap when gaps is set; valid stays up into the next word
  task automatic send_vertex(input vertex_in_t v, input bit gaps = 1'b1);
    int gap;
    gap = 0;
    if (gaps) gap = $urandom_range(0, 15) * ($urandom_range(0, 3) == 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_screen.insert(expected_screen.size(), project_vertex(v));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_screen.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    wait_cycles(60);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= RegRow3C23) mat_regs[idx] = value;
    else if (idx == RegWidth) vp_width = value[12:0];
    else if (idx == RegHeight) vp_height = value[12:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic vertex_in_t rand_vertex();
    vertex_in_t v;
    int mode;
    mode = $urandom_range(0, 3);
    v.vertex_x = rand_q(mode == 0 ? 0 : 1);
    v.vertex_y = rand_q(mode == 0 ? 0 : 1);
    v.vertex_z = rand_q(mode == 0 ? 0 : 1);
    v.vertex_w = (mode >= 2) ? 32'h0001_0000 : rand_q(mode == 0 ? 0 : 1);
    if ($urandom_range(0, 40) == 0) v.vertex_w = 0;
    return v;
  endfunction

  function automatic logic [63:0] rand_row_pair();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = ($urandom_range(0, 3) == 0) ? $urandom : rand_q(1);
    hi = ($urandom_range(0, 3) == 0) ? $urandom : rand_q(1);
    return {hi, lo};
  endfunction

  // Drive extremes through the reset identity matrix
  task automatic test_directed();
    logic signed [31:0] edges [0:5];
    vertex_in_t v;
    edges = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh0001_0000,
              -32'sh0001_0000, 32'sh0000_8000};
    for (int i = 0; i < 6; i++) begin
      v.vertex_x = edges[i];
      v.vertex_y = edges[5 - i];
      v.vertex_z = edges[i];
      v.vertex_w = edges[(i + 3) % 6];
      send_vertex(v);
    end
    // Zero clip w and near-zero clip w
    v = '{32'sh0001_0000, 32'sh0001_0000, 0, 0};
    send_vertex(v);
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 1};
    send_vertex(v);
    v = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};
    send_vertex(v);
    v = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_vertex(v);
    drain();
  endtask

  // Walk viewport sizes through extremes, including zero and out-of-range
  task automatic test_viewport_sizes();
    logic [63:0] sizes [0:5];
    sizes = '{64'd1, 64'd4096, 64'd0, 64'h1fff, 64'hffff_ffff_ffff_e123, 64'd1920};
    for (int s = 0; s < 6; s++) begin
      write_reg(RegWidth, sizes[s]);
      write_reg(RegHeight, sizes[5 - s]);
      for (int i = 0; i < 20; i++) send_vertex(rand_vertex());
      drain();
    end
  endtask

  // Random matrices with extreme coefficients; unknown indexes must be dropped
  task automatic test_random_matrices();
    for (int phase = 0; phase < 10; phase++) begin
      for (int r = 0; r <= RegRow3C23; r++) begin
        if (phase == 1) write_reg(4'(r), 64'hffff_ffff_ffff_ffff);
        else if (phase == 2) write_reg(4'(r), 64'h7fff_ffff_8000_0000);
        else if (phase == 3) write_reg(4'(r), 64'h0);
        else write_reg(4'(r), rand_row_pair());
      end
      if (phase == 3) write_reg(RegRow3C23, 64'h0001_0000_0000_0000);
      write_reg(RegWidth, $urandom_range(1, 4096));
      write_reg(RegHeight, $urandom_range(1, 4096));
      write_reg(4'($urandom_range(8, 15)), {$urandom, $urandom});
      for (int i = 0; i < 110; i++) send_vertex(rand_vertex());
      drain();
    end
  endtask

  // Hold the receiver off while words keep coming so the queue fills
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 80; i++) send_vertex(rand_vertex(), 1'b0);
      end
      begin
        wait_cycles(300);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  // Accept results with random stalls and check them in order
  initial begin
    screen_out_t exp_word;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_screen.size() == 0) begin
          unexpected_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("unexpected word %h", out_data);
        end else begin
          exp_word = expected_screen.pop_front();
          if (out_data !== exp_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp x=%h y=%h err=%b got x=%h y=%h err=%b",
                       exp_word.screen_x, exp_word.screen_y, exp_word.divide_error,
                       out_data.screen_x, out_data.screen_y, out_data.divide_error);
          end
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 15) == 0);
      else out_ready <= 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("vertex_project_to_screen_core regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    mismatch_count = 0;
    unexpected_count = 0;
    mat_regs[0] = 64'h0000_0000_0001_0000;
    mat_regs[1] = 64'h0;
    mat_regs[2] = 64'h0001_0000_0000_0000;
    mat_regs[3] = 64'h0;
    mat_regs[4] = 64'h0;
    mat_regs[5] = 64'h0001_0000_0000_0000;
    vp_width = 13'd640;
    vp_height = 13'd480;
    wait_cycles(11);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_viewport_sizes();
    test_random_matrices();
    test_backpressure();
    drain();
    if (mismatch_count == 0 && unexpected_count == 0 && expected_screen.size() == 0)
      $display("vertex_project_to_screen_core regression: pass");
    else
      $display("vertex_project_to_screen_core regression: fail");
    $finish;
  end

endmodule
